// ----- rtl/bdq_pkg.sv -----
// Shared widths, command codes and status codes for the bounded deque.
package bdq_pkg;

  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_ELEM_WIDTH = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WRITE    = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

endpackage

// ----- rtl/bdq_if.sv -----
// Valid/ready channel interfaces for deque commands and results.
interface bdq_req_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::CMD_W-1:0]  cmd;
  logic [bdq_pkg::POS_W-1:0]  position;
  logic [bdq_pkg::WORD_W-1:0] element;

  modport source (output valid, cmd, position, element, input ready);
  modport sink   (input valid, cmd, position, element, output ready);
endinterface

interface bdq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::STAT_W-1:0] status;
  logic [bdq_pkg::SIZE_W-1:0] list_size;
  logic [bdq_pkg::WORD_W-1:0] head_value;
  logic [bdq_pkg::WORD_W-1:0] tail_value;
  logic [bdq_pkg::WORD_W-1:0] read_data;

  modport source (output valid, status, list_size, head_value, tail_value, read_data,
                  input ready);
  modport sink   (input valid, status, list_size, head_value, tail_value, read_data,
                  output ready);
endinterface

// ----- rtl/bdq_store.sv -----
// Element store: one write port, one read port with registered read data.
module bdq_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bounded_deque_with_indexed_access.sv -----
// Top level of the bounded deque with indexed read and overwrite.
//
// Usage:
//   req carries one command per beat: insert head/tail, remove head/tail,
//   read at position, overwrite at position (position counted from head).
//   rsp returns exactly one beat per command: status, size after the
//   command, current head and tail elements (zero when empty) and read data.
// Timing:
//   A command is accepted when req.valid and req.ready are high. The memory
//   access (write, or the read needed for a read command or for a new
//   head/tail after a removal) is issued at that edge; the registered read
//   data then comes back and the result loads into the rsp register once
//   that register is free, which raises rsp.valid. A new command is taken
//   only after that load, as the element store has a single synchronous read port.
//   req.ready is high whenever no command is in flight, even while a result
//   waits in the rsp register; a finished command is held until that
//   register frees up, so a stalled receiver stalls the second command.
// Reset:
//   rst (synchronous) empties the list. Storage contents are not cleared and
//   need no clearing pass: head and tail words live in registers and only
//   written slots are ever read.
module bounded_deque_with_indexed_access #(
  parameter int CAPACITY   = bdq_pkg::DEF_CAPACITY,
  parameter int ELEM_WIDTH = bdq_pkg::DEF_ELEM_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  import bdq_pkg::*;

  localparam int PW = $clog2(CAPACITY);      // ring pointer width
  localparam int CW = $clog2(CAPACITY + 1);  // element count width

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  // Ring index arithmetic: operands always sum below twice the capacity.
  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    if (s >= (PW+1)'(CAPACITY)) begin
      return PW'(s - (PW+1)'(CAPACITY));
    end
    return PW'(s);
  endfunction

  state_t                state;
  logic [PW-1:0]         head_ptr;
  logic [CW-1:0]         count;
  logic [ELEM_WIDTH-1:0] head_val;
  logic [ELEM_WIDTH-1:0] tail_val;

  // command in flight
  status_t               stat_q;
  logic                  ld_head_q;
  logic                  ld_tail_q;
  logic                  ld_rd_q;

  // accept-stage decode
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic                  pos_last;
  logic [ELEM_WIDTH-1:0] elem;
  status_t               stat_next;
  logic [PW-1:0]         head_ptr_next;
  logic [CW-1:0]         count_next;
  logic [ELEM_WIDTH-1:0] head_val_next;
  logic [ELEM_WIDTH-1:0] tail_val_next;
  logic                  ld_head_next;
  logic                  ld_tail_next;
  logic                  ld_rd_next;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic                  mem_re;
  logic [PW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  // result stage
  logic                  rsp_load;
  logic [ELEM_WIDTH-1:0] head_cur;
  logic [ELEM_WIDTH-1:0] tail_cur;
  logic [63:0]           head_ext;
  logic [63:0]           tail_ext;
  logic [63:0]           rd_ext;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_ok   = 32'(req.position) < 32'(count);
  assign pos_last = 32'(req.position) == (32'(count) - 32'd1);
  assign elem     = ELEM_WIDTH'(req.element);

  always_comb begin
    stat_next     = STAT_OK;
    head_ptr_next = head_ptr;
    count_next    = count;
    head_val_next = head_val;
    tail_val_next = tail_val;
    ld_head_next  = 1'b0;
    ld_tail_next  = 1'b0;
    ld_rd_next    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = head_ptr;
    mem_re        = 1'b0;
    mem_raddr     = head_ptr;

    case (req.cmd)
      CMD_INS_HEAD: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          head_ptr_next = (head_ptr == '0) ? PW'(CAPACITY - 1) : head_ptr - PW'(1);
          count_next    = count + CW'(1);
          mem_we        = 1'b1;
          mem_waddr     = head_ptr_next;
          head_val_next = elem;
          if (empty) begin
            tail_val_next = elem;
          end
        end
      end
      CMD_INS_TAIL: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          count_next    = count + CW'(1);
          mem_we        = 1'b1;
          mem_waddr     = wrap({1'b0, head_ptr} + (PW+1)'(count));
          tail_val_next = elem;
          if (empty) begin
            head_val_next = elem;
          end
        end
      end
      CMD_REM_HEAD: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          head_ptr_next = wrap({1'b0, head_ptr} + (PW+1)'(1));
          count_next    = count - CW'(1);
          // new head comes out of the store
          if (count_next != '0) begin
            mem_re       = 1'b1;
            mem_raddr    = head_ptr_next;
            ld_head_next = 1'b1;
          end
        end
      end
      CMD_REM_TAIL: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if (count_next != '0) begin
            mem_re       = 1'b1;
            mem_raddr    = wrap({1'b0, head_ptr} + (PW+1)'(count) - (PW+1)'(2));
            ld_tail_next = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          mem_re     = 1'b1;
          mem_raddr  = wrap({1'b0, head_ptr} + (PW+1)'(req.position));
          ld_rd_next = 1'b1;
        end else begin
          stat_next = STAT_RANGE;
        end
      end
      CMD_WRITE: begin
        if (pos_ok) begin
          mem_we    = 1'b1;
          mem_waddr = wrap({1'b0, head_ptr} + (PW+1)'(req.position));
          // keep the cached end words coherent
          if (req.position == '0) begin
            head_val_next = elem;
          end
          if (pos_last) begin
            tail_val_next = elem;
          end
        end else begin
          stat_next = STAT_RANGE;
        end
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
  end

  bdq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEM_WIDTH),
    .AW    (PW)
  ) u_store (
    .clk   (clk),
    .we    (accept && mem_we),
    .waddr (mem_waddr),
    .wdata (elem),
    .re    (accept && mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result stage: read data stays put while waiting on a full rsp register.
  assign rsp_load = (state == ST_BUSY) && (!rsp.valid || rsp.ready);
  assign head_cur = ld_head_q ? mem_rdata : head_val;
  assign tail_cur = ld_tail_q ? mem_rdata : tail_val;
  assign head_ext = (count == '0) ? 64'd0 : 64'(head_cur);
  assign tail_ext = (count == '0) ? 64'd0 : 64'(tail_cur);
  assign rd_ext   = ld_rd_q ? 64'(mem_rdata) : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_ptr  <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
      ld_head_q <= 1'b0;
      ld_tail_q <= 1'b0;
      ld_rd_q   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_BUSY;
            head_ptr  <= head_ptr_next;
            count     <= count_next;
            head_val  <= head_val_next;
            tail_val  <= tail_val_next;
            stat_q    <= stat_next;
            ld_head_q <= ld_head_next;
            ld_tail_q <= ld_tail_next;
            ld_rd_q   <= ld_rd_next;
          end
        end
        ST_BUSY: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
          head_val <= head_cur;
          tail_val <= tail_cur;
        end
        default: state <= ST_IDLE;
      endcase

      if (rsp_load) begin
        rsp.valid      <= 1'b1;
        rsp.status     <= stat_q;
        rsp.list_size  <= SIZE_W'(count);
        rsp.head_value <= head_ext[WORD_W-1:0];
        rsp.tail_value <= tail_ext[WORD_W-1:0];
        rsp.read_data  <= rd_ext[WORD_W-1:0];
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count) && $stable(head_ptr))
    else $error("list state changed without a command");

  a_full_insert_holds: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.cmd == CMD_INS_HEAD || req.cmd == CMD_INS_TAIL)
    |=> $stable(count) && stat_q == STAT_FULL)
    else $error("insert into full list not rejected");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_BUSY && !req.ready)
    else $error("second command taken while one is in flight");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bounded deque: directed script, then random grow, shrink and churn phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH       = DEF_CAPACITY;
  localparam int LONG_HOLD   = 400;   // one long receiver stall, to back the block up
  localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES = 16;    // settle time after the last result

  // Codes outside cmd_t; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // One result beat as the block reports it.
  typedef struct packed {
    status_t             status;
    logic [SIZE_W-1:0]   list_size;
    logic [WORD_W-1:0]   head_word;
    logic [WORD_W-1:0]   tail_word;
    logic [WORD_W-1:0]   read_word;
  } rsp_t;

  // One row of the directed script. When typed is set, want is the answer
  // taken straight from the spec; otherwise the predictor supplies it.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   elem;
    logic                typed;
    rsp_t                want;
  } step_row_t;

  typedef enum int { PH_GROW, PH_SHRINK, PH_CHURN } phase_t;

  localparam rsp_t UNTYPED = '0;

  localparam int SCRIPT_LEN = 24;
  localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty list: both removals rejected, any index out of range
    '{CMD_REM_HEAD, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_EMPTY, 9'd0, 32'h0, 32'h0, 32'h0}},
    '{CMD_REM_TAIL, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_EMPTY, 9'd0, 32'h0, 32'h0, 32'h0}},
    '{CMD_READ,     8'd0,   32'h0000_0000, 1'b1,
      '{STAT_RANGE, 9'd0, 32'h0, 32'h0, 32'h0}},
    '{CMD_WRITE,    8'd0,   32'hFFFF_FFFF, 1'b1,
      '{STAT_RANGE, 9'd0, 32'h0, 32'h0, 32'h0}},
    // unused codes do nothing
    '{CMD_RSVD6,    8'd255, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK,    9'd0, 32'h0, 32'h0, 32'h0}},
    '{CMD_RSVD7,    8'd255, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK,    9'd0, 32'h0, 32'h0, 32'h0}},
    // build [12345678, FFFFFFFF, 00000000]; head insert wraps the ring pointer
    '{CMD_INS_HEAD, 8'd0,   32'hFFFF_FFFF, 1'b1,
      '{STAT_OK,    9'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}},
    '{CMD_INS_TAIL, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_OK,    9'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0}},
    '{CMD_INS_HEAD, 8'd255, 32'h1234_5678, 1'b1,
      '{STAT_OK,    9'd3, 32'h1234_5678, 32'h0000_0000, 32'h0}},
    '{CMD_READ,     8'd0,   32'h0000_0000, 1'b1,
      '{STAT_OK,    9'd3, 32'h1234_5678, 32'h0000_0000, 32'h1234_5678}},
    '{CMD_READ,     8'd1,   32'hFFFF_FFFF, 1'b1,
      '{STAT_OK,    9'd3, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{CMD_READ,     8'd2,   32'h0000_0000, 1'b1,
      '{STAT_OK,    9'd3, 32'h1234_5678, 32'h0000_0000, 32'h0}},
    // index equal to the size, and the top index, are out of range
    '{CMD_READ,     8'd3,   32'h0000_0000, 1'b1,
      '{STAT_RANGE, 9'd3, 32'h1234_5678, 32'h0000_0000, 32'h0}},
    '{CMD_READ,     8'd255, 32'h0000_0000, 1'b1,
      '{STAT_RANGE, 9'd3, 32'h1234_5678, 32'h0000_0000, 32'h0}},
    '{CMD_WRITE,    8'd2,   32'hA5A5_A5A5, 1'b1,
      '{STAT_OK,    9'd3, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0}},
    '{CMD_WRITE,    8'd3,   32'h5A5A_5A5A, 1'b1,
      '{STAT_RANGE, 9'd3, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0}},
    '{CMD_RSVD6,    8'd1,   32'hDEAD_BEEF, 1'b0, UNTYPED},
    '{CMD_REM_TAIL, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_OK,    9'd2, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0}},
    '{CMD_REM_HEAD, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_OK,    9'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}},
    '{CMD_INS_TAIL, 8'd0,   32'h5A5A_5A5A, 1'b0, UNTYPED},
    '{CMD_READ,     8'd1,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_REM_HEAD, 8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_REM_TAIL, 8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_REM_TAIL, 8'd0,   32'h0000_0000, 1'b1,
      '{STAT_EMPTY, 9'd0, 32'h0, 32'h0, 32'h0}}
  };

  logic clk = 1'b0;
  logic rst;

  bdq_req_if req();
  bdq_rsp_if rsp();

  bounded_deque_with_indexed_access dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: ring of words, head index and fill count, same as the block.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] deque_words [DEPTH];
  logic [POS_W-1:0]  front_idx;
  logic [SIZE_W-1:0] fill_count;

  rsp_t expected_q [$];

  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned full_rejects    = 0;
  int unsigned empty_rejects   = 0;
  int unsigned range_rejects   = 0;
  int unsigned peak_size       = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned burst_left      = 0;

  function automatic rsp_t apply_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                     logic [WORD_W-1:0] e);
    rsp_t r;
    logic [POS_W-1:0] slot;
    r = '0;
    r.status = STAT_OK;
    case (c)
      CMD_INS_HEAD: begin
        if (fill_count == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          front_idx = front_idx - 1'b1;  // 8-bit wrap is the ring modulo
          deque_words[front_idx] = e;
          fill_count++;
        end
      end
      CMD_INS_TAIL: begin
        if (fill_count == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          slot = front_idx + fill_count[POS_W-1:0];
          deque_words[slot] = e;
          fill_count++;
        end
      end
      CMD_REM_HEAD: begin
        if (fill_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          front_idx = front_idx + 1'b1;
          fill_count--;
        end
      end
      CMD_REM_TAIL: begin
        if (fill_count == 0) r.status = STAT_EMPTY;
        else fill_count--;
      end
      CMD_READ: begin
        slot = front_idx + p;
        if ({1'b0, p} < fill_count) r.read_word = deque_words[slot];
        else r.status = STAT_RANGE;
      end
      CMD_WRITE: begin
        slot = front_idx + p;
        if ({1'b0, p} < fill_count) deque_words[slot] = e;
        else r.status = STAT_RANGE;
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.list_size = fill_count;
    if (fill_count != 0) begin
      slot = front_idx + fill_count[POS_W-1:0] - 1'b1;
      r.head_word = deque_words[front_idx];
      r.tail_word = deque_words[slot];
    end
    return r;
  endfunction

  // Random beat shaped by phase: grow toward full, shrink toward empty, or churn.
  function automatic void pick_beat(input phase_t ph, output logic [CMD_W-1:0] c,
                                    output logic [POS_W-1:0] p,
                                    output logic [WORD_W-1:0] e);
    int unsigned roll;
    logic [CMD_W-1:0] ins, rem, acc, rsvd;
    roll = $urandom_range(0, 99);
    e    = $urandom();
    // mostly land inside the list so reads and overwrites do real work
    if (fill_count != 0 && $urandom_range(0, 4) != 0)
      p = POS_W'($urandom_range(0, fill_count - 1));
    else
      p = POS_W'($urandom_range(0, 255));
    ins  = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
    rem  = $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
    acc  = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    rsvd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    case (ph)
      PH_GROW: begin
        if (roll < 88)      c = ins;
        else if (roll < 95) c = acc;
        else if (roll < 98) c = rem;
        else                c = rsvd;
      end
      PH_SHRINK: begin
        if (roll < 88)      c = rem;
        else if (roll < 95) c = acc;
        else if (roll < 98) c = ins;
        else                c = rsvd;
      end
      default: begin
        if (roll < 25)      c = ins;
        else if (roll < 50) c = rem;
        else if (roll < 75) c = CMD_READ;
        else if (roll < 96) c = CMD_WRITE;
        else                c = rsvd;
      end
    endcase
  endfunction

  // Drive one command beat and wait for it to be taken. Called at a rising
  // edge; bursts of back-to-back beats are mostly separated by random gaps.
  task automatic issue(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                       input logic [WORD_W-1:0] e, input logic typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      // occasionally a long burst so some stretches run with no gaps at all
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    req.valid    <= 1'b1;
    req.cmd      <= c;
    req.position <= p;
    req.element  <= e;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    // accepted at this edge
    predicted = apply_cmd(c, p, e);
    expected_q.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [CMD_W-1:0]  c;
    logic [POS_W-1:0]  p;
    logic [WORD_W-1:0] e;
    front_idx  = '0;
    fill_count = '0;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.cmd      <= CMD_READ;
    req.position <= '0;
    req.element  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script
    for (int i = 0; i < SCRIPT_LEN; i++)
      issue(SCRIPT[i].cmd, SCRIPT[i].pos, SCRIPT[i].elem, SCRIPT[i].typed, SCRIPT[i].want);

    // grow to full, poke at the full list, drain to half, then churn
    while (fill_count != DEPTH) begin
      pick_beat(PH_GROW, c, p, e);
      issue(c, p, e, 1'b0, UNTYPED);
    end
    repeat (20) begin
      pick_beat(PH_GROW, c, p, e);
      issue(c, p, e, 1'b0, UNTYPED);
    end
    while (fill_count > DEPTH / 2) begin
      pick_beat(PH_SHRINK, c, p, e);
      issue(c, p, e, 1'b0, UNTYPED);
    end
    repeat (20) begin
      pick_beat(PH_CHURN, c, p, e);
      issue(c, p, e, 1'b0, UNTYPED);
    end

    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // let any stray extra result show up before calling it
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d commands, %0d results checked, peak size %0d of %0d",
             items_sent, results_checked, peak_size, DEPTH);
    $display("rejections seen: %0d full, %0d empty, %0d out of range; %0d mismatches",
             full_rejects, empty_rejects, range_rejects, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: its own stall pattern, cycling through four ready patterns, plus one
  // long hold-off so the block fills its result slots and drops req.ready.
  // ---------------------------------------------------------------------
  initial begin : result_side
    int unsigned tick;
    bit          held;
    tick = 0;
    held = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held && results_checked >= 120) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case ((tick / 128) % 4)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp.ready <= ((tick % 5) < 2);
          default: rsp.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every result beat against the oldest expectation.
  // ---------------------------------------------------------------------
  function automatic void note_failure(string what, rsp_t want, rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected: st=%0d size=%0d head=%h tail=%h rd=%h",
               want.status, want.list_size, want.head_word, want.tail_word, want.read_word);
      $display("  actual:   st=%0d size=%0d head=%h tail=%h rd=%h",
               got.status, got.list_size, got.head_word, got.tail_word, got.read_word);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t got, want;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = '{status_t'(rsp.status), rsp.list_size, rsp.head_value, rsp.tail_value,
              rsp.read_data};
      if (expected_q.size() == 0) begin
        note_failure("result beat with nothing pending", '0, got);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        case (want.status)
          STAT_FULL:  full_rejects++;
          STAT_EMPTY: empty_rejects++;
          STAT_RANGE: range_rejects++;
          default: ;
        endcase
        if (want.list_size > peak_size) peak_size = want.list_size;
        if (got !== want) note_failure($sformatf("result %0d differs", results_checked),
                                       want, got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: counts cycles in which no beat moves on either channel.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no beat moved for %0d cycles, %0d results still pending",
             STALL_LIMIT, expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
